// File: rtl/sphere_contact_generation_macros.svh
// assertion macros for the sphere contact generation block
// no dependencies; included by the top level only
`ifndef SPHERE_CONTACT_GENERATION_MACROS_SVH
`define SPHERE_CONTACT_GENERATION_MACROS_SVH
`ifndef SYNTHESIS
`define SCG_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SCG_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SCG_ASSERT(name, clk, rstn, prop)
`define SCG_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif
`endif

// File: rtl/scg_pkg.sv
// shared types and constants for the sphere contact generation block
// no dependencies
`default_nettype none
package scg_pkg;
  localparam logic [14:0] NormOne  = 15'd16384;
  localparam int          RootBits = 32;
  localparam int          RootIdxW = 5;
  localparam int          QuotBits = 15;
  localparam int          QIdxW    = 4;
  localparam int          NumW     = 47;

  typedef enum logic [1:0] {KIND_MISS, KIND_UP, KIND_NORM} kind_e;

  typedef struct packed {
    logic            vld;
    kind_e           kind;
    logic            box;
    logic [31:0]     dbase;
    logic [2:0]      neg;
    logic [2:0][31:0] mag;
  } sq_ctl_t;

  typedef struct packed {
    sq_ctl_t              ctl;
    logic [63:0]          rem;
    logic [RootBits-1:0]  root;
  } sq_item_t;

  typedef struct packed {
    logic        vld;
    kind_e       kind;
    logic [31:0] depth;
    logic [2:0]  neg;
  } dv_ctl_t;

  typedef struct packed {
    dv_ctl_t                    ctl;
    logic [RootBits-1:0]        dlen;
    logic [2:0][NumW-1:0]       rem;
    logic [2:0][QuotBits-1:0]   quo;
  } dv_item_t;
endpackage
`default_nettype wire

// File: rtl/sphere_contact_generation.sv
// sphere contact generation top level: front stages, root and divider chains
// depends on scg_pkg, scg_sqrt_cell, scg_div_cell, sphere_contact_generation_macros.svh
//
// usage: one query item on the slave stream (sphere A plus a second sphere or
// a box, chosen by s_axis_tuser) gives one result item on the master stream
// (hit, unit normal in Q2.14, penetration depth).
// pipeline: from input accept to m_axis_tvalid an item passes three front stages
// (differences, squares, sum and classify), 32 root cells, one depth stage,
// 15 divider cells and the output register.
// throughput: one item per cycle; every cell hands its item on while not frozen
// stall: an output register plus one skid register; when the receiver holds
// off, the next result parks in the skid register and the whole chain, and
// s_axis_tready, freeze until the output is taken.
// reset: all valid flags clear, no item in flight, outputs not valid.
`default_nettype none
`include "sphere_contact_generation_macros.svh"
module sphere_contact_generation import scg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, half_x, half_y, half_z
  input  logic [351:0] s_axis_tdata,
  // action
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, normal_x, normal_y, normal_z, depth
  output logic [87:0]  m_axis_tdata
);
  logic en;
  logic skid_vq;
  assign en            = !skid_vq;
  assign s_axis_tready = en;

  // stage a: differences and box clamp
  logic signed [2:0][33:0] a_s, b_s, h_s, lo, hi, cl, d_d;
  logic [30:0] ar_in, br_in;
  always_comb begin
    a_s[0] = {{2{s_axis_tdata[31]}},  s_axis_tdata[31:0]};
    a_s[1] = {{2{s_axis_tdata[63]}},  s_axis_tdata[63:32]};
    a_s[2] = {{2{s_axis_tdata[95]}},  s_axis_tdata[95:64]};
    ar_in  = s_axis_tdata[126:96];
    b_s[0] = {{2{s_axis_tdata[158]}}, s_axis_tdata[158:127]};
    b_s[1] = {{2{s_axis_tdata[190]}}, s_axis_tdata[190:159]};
    b_s[2] = {{2{s_axis_tdata[222]}}, s_axis_tdata[222:191]};
    br_in  = s_axis_tdata[253:223];
    h_s[0] = {3'd0, s_axis_tdata[284:254]};
    h_s[1] = {3'd0, s_axis_tdata[315:285]};
    h_s[2] = {3'd0, s_axis_tdata[346:316]};
    for (int i = 0; i < 3; i++) begin
      lo[i] = b_s[i] - h_s[i];
      hi[i] = b_s[i] + h_s[i];
      if ($signed(a_s[i]) < $signed(lo[i])) begin
        cl[i] = lo[i];
      end else if ($signed(a_s[i]) > $signed(hi[i])) begin
        cl[i] = hi[i];
      end else begin
        cl[i] = a_s[i];
      end
      d_d[i] = s_axis_tuser[0] ? (a_s[i] - cl[i]) : (a_s[i] - b_s[i]);
    end
  end

  logic                    va_q, acta_q;
  logic signed [2:0][33:0] da_q;
  logic [30:0]             ara_q;
  logic [31:0]             rsa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      acta_q <= 1'b0;
      da_q   <= '0;
      ara_q  <= '0;
      rsa_q  <= '0;
    end else if (en) begin
      va_q   <= s_axis_tvalid;
      acta_q <= s_axis_tuser[0];
      da_q   <= d_d;
      ara_q  <= ar_in;
      rsa_q  <= {1'b0, ar_in} + {1'b0, br_in};
    end
  end

  // stage b: magnitudes and squares
  logic [2:0][33:0] mg;
  logic [2:0]       ng;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ng[i] = da_q[i][33];
      mg[i] = ng[i] ? 34'(-da_q[i]) : 34'(da_q[i]);
    end
  end

  logic             vb_q, actb_q, bigb_q;
  logic [2:0][63:0] sqb_q;
  logic [63:0]      rrb_q;
  logic [2:0]       ngb_q;
  logic [2:0][31:0] mgb_q;
  logic [30:0]      arb_q;
  logic [31:0]      rsb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q   <= 1'b0;
      actb_q <= 1'b0;
      bigb_q <= 1'b0;
      sqb_q  <= '0;
      rrb_q  <= '0;
      ngb_q  <= '0;
      mgb_q  <= '0;
      arb_q  <= '0;
      rsb_q  <= '0;
    end else if (en) begin
      vb_q   <= va_q;
      actb_q <= acta_q;
      bigb_q <= (|mg[0][33:32]) | (|mg[1][33:32]) | (|mg[2][33:32]);
      for (int i = 0; i < 3; i++) begin
        sqb_q[i] <= mg[i][31:0] * mg[i][31:0];
        mgb_q[i] <= mg[i][31:0];
      end
      rrb_q  <= rsa_q * rsa_q;
      ngb_q  <= ng;
      arb_q  <= ara_q;
      rsb_q  <= rsa_q;
    end
  end

  // stage c: squared distance and classification
  logic [65:0] sum;
  sq_item_t    sqc_d, sqc_q;
  always_comb begin
    sum              = {2'd0, sqb_q[0]} + {2'd0, sqb_q[1]} + {2'd0, sqb_q[2]};
    sqc_d.ctl.vld    = vb_q;
    sqc_d.ctl.box    = actb_q;
    sqc_d.ctl.neg    = ngb_q;
    sqc_d.ctl.mag    = mgb_q;
    sqc_d.ctl.dbase  = actb_q ? {1'b0, arb_q} : rsb_q;
    sqc_d.rem        = sum[63:0];
    sqc_d.root       = '0;
    if (bigb_q || (|sum[65:64]) || (!actb_q && (sum[63:0] > rrb_q))) begin
      sqc_d.ctl.kind = KIND_MISS;
    end else if (sum[63:0] == 64'd0) begin
      sqc_d.ctl.kind = KIND_UP;
    end else begin
      sqc_d.ctl.kind = KIND_NORM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqc_q <= '0;
    end else if (en) begin
      sqc_q <= sqc_d;
    end
  end

  // square root chain
  sq_item_t sq_chain [RootBits+1];
  assign sq_chain[0] = sqc_q;
  for (genvar g = 0; g < RootBits; g++) begin : g_sqrt
    scg_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .bit_i  (RootIdxW'(RootBits - 1 - g)),
      .item_i (sq_chain[g]),
      .item_o (sq_chain[g+1])
    );
  end

  // depth stage and numerators
  sq_item_t sq_end;
  dv_item_t dv_d, dv_q;
  assign sq_end = sq_chain[RootBits];
  always_comb begin
    dv_d.ctl.vld   = sq_end.ctl.vld;
    dv_d.ctl.neg   = sq_end.ctl.neg;
    dv_d.ctl.kind  = sq_end.ctl.kind;
    dv_d.ctl.depth = sq_end.ctl.dbase;
    dv_d.dlen      = sq_end.root;
    dv_d.quo       = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d.rem[i] = {1'b0, sq_end.ctl.mag[i], 14'd0} + {16'd0, sq_end.root[31:1]};
    end
    if (sq_end.ctl.kind == KIND_NORM) begin
      if (sq_end.ctl.box && (sq_end.ctl.dbase <= sq_end.root)) begin
        dv_d.ctl.kind = KIND_MISS;
      end
      dv_d.ctl.depth = sq_end.ctl.dbase - sq_end.root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= dv_d;
    end
  end

  // divider chain
  dv_item_t dv_chain [QuotBits+1];
  assign dv_chain[0] = dv_q;
  for (genvar g = 0; g < QuotBits; g++) begin : g_div
    scg_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .k_i    (QIdxW'(QuotBits - 1 - g)),
      .item_i (dv_chain[g]),
      .item_o (dv_chain[g+1])
    );
  end

  // result assembly
  dv_item_t         dv_end;
  logic [2:0][15:0] nrm;
  logic [15:0]      qv;
  logic [87:0]      res;
  assign dv_end = dv_chain[QuotBits];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv     = (dv_end.quo[i] > NormOne) ? {1'b0, NormOne} : {1'b0, dv_end.quo[i]};
      nrm[i] = dv_end.ctl.neg[i] ? 16'(-qv) : qv;
    end
    res = '0;
    case (dv_end.ctl.kind)
      KIND_UP: begin
        res[0]     = 1'b1;
        res[32:17] = {1'b0, NormOne};
        res[80:49] = dv_end.ctl.depth;
      end
      KIND_NORM: begin
        res[0]     = 1'b1;
        res[16:1]  = nrm[0];
        res[32:17] = nrm[1];
        res[48:33] = nrm[2];
        res[80:49] = dv_end.ctl.depth;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // output register and skid
  logic        out_vq;
  logic [87:0] out_q, skid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
      out_q   <= '0;
      skid_q  <= '0;
    end else if (out_vq && !m_axis_tready) begin
      if (en && dv_end.ctl.vld) begin
        skid_q  <= res;
        skid_vq <= 1'b1;
      end
    end else if (skid_vq) begin
      out_q   <= skid_q;
      out_vq  <= 1'b1;
      skid_vq <= 1'b0;
    end else begin
      out_q  <= res;
      out_vq <= dv_end.ctl.vld;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = out_q;

  `SCG_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_vq |-> out_vq)
  `SCG_ASSERT(a_miss_zero, clk_i, rst_ni, (out_vq && !out_q[0]) |-> (out_q[87:1] == 87'd0))
  `SCG_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_vq && m_axis_tready, !skid_vq)
endmodule
`default_nettype wire

// File: rtl/scg_sqrt_cell.sv
// one cell of the square root chain: settles one root bit per item
// depends on scg_pkg
`default_nettype none
module scg_sqrt_cell import scg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [RootIdxW-1:0] bit_i,
  input  sq_item_t            item_i,
  output sq_item_t            item_o
);
  logic [63:0] trial;
  logic [5:0]  sh;
  sq_item_t    item_d, item_q;

  always_comb begin
    sh     = {1'b0, bit_i} + 6'd1;
    trial  = ({32'd0, item_i.root} << sh) | (64'd1 << {bit_i, 1'b0});
    item_d = item_i;
    if (trial <= item_i.rem) begin
      item_d.rem  = item_i.rem - trial;
      item_d.root = item_i.root | (RootBits'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;
endmodule
`default_nettype wire

// File: rtl/scg_div_cell.sv
// one cell of the normal divider chain: one quotient bit for all three axes
// depends on scg_pkg
`default_nettype none
module scg_div_cell import scg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [QIdxW-1:0] k_i,
  input  dv_item_t         item_i,
  output dv_item_t         item_o
);
  logic [NumW-1:0] sub;
  dv_item_t        item_d, item_q;

  always_comb begin
    sub    = {15'd0, item_i.dlen} << k_i;
    item_d = item_i;
    for (int i = 0; i < 3; i++) begin
      if (item_i.rem[i] >= sub) begin
        item_d.rem[i] = item_i.rem[i] - sub;
        item_d.quo[i] = item_i.quo[i] | (QuotBits'(1) << k_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;
endmodule
`default_nettype wire
